FILE: sv/wor_pkg.sv
// Package for the wormhole output reserver.
// Holds the switch size, field widths and the request register type; no dependencies.
package wor_pkg;

  localparam int NUM_OUTPUTS = 8;
  localparam int NUM_INPUTS  = 16;

  localparam int ID_W   = $clog2(NUM_INPUTS);
  localparam int PORT_W = $clog2(NUM_OUTPUTS);

  typedef logic [ID_W-1:0]   input_id_t;
  typedef logic [PORT_W-1:0] port_t;

  typedef struct packed {
    input_id_t input_id;
    logic      last_flit;
    logic      round_start;
  } req_t;

endpackage

FILE: sv/wormhole_output_reserver.sv
// Wormhole output reserver: a switch output allocator with per-output reservations.
// Depends on wor_pkg for the switch size, field widths and the request register type.
// A request is captured in the input register; its result is then loaded into the result register that drives done.
// Throughput: one request per cycle; busy stays low, because the reservation
// table and round mask update at the same edge that loads the result register.
// Reset (rst, synchronous) frees every reservation and clears the round mask.
module wormhole_output_reserver (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  wor_pkg::input_id_t    input_id,
  input  logic                  last_flit,
  input  logic                  round_start,
  output logic                  done,
  output logic                  granted,
  output wor_pkg::port_t        output_port
);
  import wor_pkg::*;

  localparam int IDX_W = PORT_W;

  logic                   req_valid;
  req_t                   req;

  logic [NUM_OUTPUTS-1:0] res_valid;
  input_id_t              res_owner [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] used;

  logic [NUM_OUTPUTS-1:0] used_base;
  logic [NUM_OUTPUTS-1:0] own_hit;
  logic [NUM_OUTPUTS-1:0] free_vec;
  logic [IDX_W-1:0]       own_idx;
  logic [IDX_W-1:0]       free_idx;
  logic                   id_ok;
  logic                   grant_next;
  logic [IDX_W-1:0]       grant_idx;
  logic                   take_own;
  logic [NUM_OUTPUTS-1:0] used_next;

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
    if (start && !busy) begin
      req.input_id    <= input_id;
      req.last_flit   <= last_flit;
      req.round_start <= round_start;
    end
  end

  // Parallel compares over the reservation table and lowest-index selection.
  always_comb begin
    used_base = req.round_start ? '0 : used;
    id_ok     = int'(req.input_id) < NUM_INPUTS;
    own_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      own_hit[i]  = res_valid[i] && (res_owner[i] == req.input_id);
      free_vec[i] = !res_valid[i] && !used_base[i];
    end
    for (int i = NUM_OUTPUTS - 1; i >= 0; i--) begin
      if (own_hit[i]) begin
        own_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    take_own   = |own_hit;
    grant_idx  = take_own ? own_idx : free_idx;
    // An owning input that already used its output this round waits; it never
    // falls back to a free output.
    if (!id_ok) begin
      grant_next = 1'b0;
    end else if (take_own) begin
      grant_next = !used_base[own_idx];
    end else begin
      grant_next = |free_vec;
    end
    used_next = used_base;
    if (grant_next) begin
      used_next[grant_idx] = 1'b1;
    end
  end

  // Table, round mask and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= '0;
      used        <= '0;
      done        <= 1'b0;
      granted     <= 1'b0;
      output_port <= '0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        used        <= used_next;
        granted     <= grant_next;
        output_port <= grant_next ? grant_idx : '0;
        if (grant_next) begin
          if (take_own && req.last_flit) begin
            res_valid[grant_idx] <= 1'b0;
          end else if (!take_own && !req.last_flit) begin
            res_valid[grant_idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && grant_next && !take_own && !req.last_flit) begin
      res_owner[grant_idx] <= req.input_id;
    end
  end

endmodule

FILE: sv/wor_checker.sv
// Port-level checker for the wormhole output reserver, with its bind statement.
// Depends on wor_pkg for the switch size and field widths.
module wor_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               round_start,
  input logic               done,
  input logic               granted,
  input wor_pkg::port_t     output_port
);
  import wor_pkg::*;

  // Every accepted transaction yields exactly one result, through the input and result registers.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)))
    else $error("result strobe does not match accepted transactions");

  a_idle_port: assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (output_port == '0))
    else $error("output_port nonzero without a grant");

  a_port_range: assert property (@(posedge clk) disable iff (rst)
    (done && granted) |-> (int'(output_port) < NUM_OUTPUTS))
    else $error("granted output out of range");

  // Within one round, two back-to-back grants never name the same output.
  a_round_once: assert property (@(posedge clk) disable iff (rst)
    (done && granted && $past(done) && $past(granted) && !$past(rst, 2)
     && $past(start, 2) && !$past(round_start, 2))
    |-> (output_port != $past(output_port)))
    else $error("output granted twice in one round");

endmodule

bind wormhole_output_reserver wor_checker u_wor_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .round_start(round_start),
  .done(done),
  .granted(granted),
  .output_port(output_port)
);
